@@ sv/pcmi_pkg.sv @@
// Package for the pulse capture unit: constants, codes and shared types.
`default_nettype none
package pcmi_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int ENTRY_AW    = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int TS_W     = 16;
  localparam int CMD_W    = 3;
  localparam int IDX_W    = 5;
  localparam int STATUS_W = 2;
  localparam int REJ_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [TS_W-1:0]  MIN_WIDTH_RESET = 16'd625;
  localparam logic [TS_W-1:0]  MIN_GAP_RESET   = 16'd3125;
  localparam logic [TS_W-1:0]  VALUE_OOR       = 16'hFFFF;
  localparam logic [REJ_W-1:0] REJECT_MAX      = 8'hFF;

  localparam logic [CMD_W-1:0] CMD_START         = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FALL          = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RISE          = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MEDIAN        = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_WIDTH    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ_INTERVAL = 3'd5;

  localparam logic [STATUS_W-1:0] EDGE_NONE      = 2'd0;
  localparam logic [STATUS_W-1:0] EDGE_ACCEPTED  = 2'd1;
  localparam logic [STATUS_W-1:0] EDGE_NARROW    = 2'd2;
  localparam logic [STATUS_W-1:0] EDGE_TOO_CLOSE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP   = 2'd1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_FEED  = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_SHIFT = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  // Control for the sorting chain.
  typedef struct packed {
    logic clear;
    logic shift;
  } chain_ctl_t;

endpackage
`default_nettype wire

@@ sv/pcmi_if.sv @@
// Channel interfaces of the pulse capture unit: input, result and configuration.
`default_nettype none
interface pcmi_in_if;
  logic                       valid;
  logic                       ready;
  logic [pcmi_pkg::CMD_W-1:0] cmd;
  logic [pcmi_pkg::TS_W-1:0]  timestamp;
  logic [pcmi_pkg::IDX_W-1:0] index;
  modport source (output valid, output cmd, output timestamp, output index, input ready);
  modport sink   (input valid, input cmd, input timestamp, input index, output ready);
endinterface

interface pcmi_out_if;
  logic                          valid;
  logic                          ready;
  logic [pcmi_pkg::TS_W-1:0]     value;
  logic [pcmi_pkg::STATUS_W-1:0] edge_status;
  logic [pcmi_pkg::CNT_W-1:0]    pulse_total;
  logic [pcmi_pkg::REJ_W-1:0]    reject_total;
  modport source (output valid, output value, output edge_status, output pulse_total,
                  output reject_total, input ready);
  modport sink   (input valid, input value, input edge_status, input pulse_total,
                  input reject_total, output ready);
endinterface

interface pcmi_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pcmi_pkg::CFG_IDX_W-1:0] index;
  logic [pcmi_pkg::TS_W-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ sv/pcmi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pcmi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

@@ sv/pcmi_cell.sv @@
// One insertion-sort cell: keeps the smaller value, hands the larger one on.
`default_nettype none
module pcmi_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire pcmi_pkg::chain_ctl_t      ctl,
  input  wire logic [pcmi_pkg::TS_W-1:0] in_data,
  input  wire logic                      in_vld,
  input  wire logic [pcmi_pkg::TS_W-1:0] shr_data,
  output logic      [pcmi_pkg::TS_W-1:0] held_data,
  output logic      [pcmi_pkg::TS_W-1:0] pass_data,
  output logic                           pass_vld
);

  logic [pcmi_pkg::TS_W-1:0] held_r, held_nxt;
  logic                      hv_r, hv_nxt;
  logic [pcmi_pkg::TS_W-1:0] pass_r, pass_nxt;
  logic                      pv_r, pv_nxt;

  always_comb begin
    held_nxt = held_r;
    hv_nxt   = hv_r;
    pass_nxt = pass_r;
    pv_nxt   = 1'b0;
    if (ctl.clear) begin
      hv_nxt = 1'b0;
    end else if (ctl.shift) begin
      held_nxt = shr_data;
    end else if (in_vld) begin
      if (!hv_r) begin
        held_nxt = in_data;
        hv_nxt   = 1'b1;
      end else if (in_data < held_r) begin
        held_nxt = in_data;
        pass_nxt = held_r;
        pv_nxt   = 1'b1;
      end else begin
        pass_nxt = in_data;
        pv_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= 1'b0;
      pv_r <= 1'b0;
    end else begin
      hv_r <= hv_nxt;
      pv_r <= pv_nxt;
    end
    held_r <= held_nxt;
    pass_r <= pass_nxt;
  end

  assign held_data = held_r;
  assign pass_data = pass_r;
  assign pass_vld  = pv_r;

endmodule
`default_nettype wire

@@ sv/pcmi_chain.sv @@
// Row of sorting cells; after feeding, shifting toward the head brings any rank to cell zero.
`default_nettype none
module pcmi_chain (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire pcmi_pkg::chain_ctl_t      ctl,
  input  wire logic [pcmi_pkg::TS_W-1:0] feed_data,
  input  wire logic                      feed_vld,
  output logic      [pcmi_pkg::TS_W-1:0] head_data
);

  localparam int N = pcmi_pkg::MAX_ENTRIES;

  logic [pcmi_pkg::TS_W-1:0] link_data [N+1];
  logic                      link_vld  [N+1];
  logic [pcmi_pkg::TS_W-1:0] held      [N+1];

  assign link_data[0] = feed_data;
  assign link_vld[0]  = feed_vld;
  // Nothing lies beyond the last cell; shifting fills it with the top code.
  assign held[N]      = pcmi_pkg::VALUE_OOR;

  for (genvar g = 0; g < N; g++) begin : g_cell
    pcmi_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .in_data   (link_data[g]),
      .in_vld    (link_vld[g]),
      .shr_data  (held[g+1]),
      .held_data (held[g]),
      .pass_data (link_data[g+1]),
      .pass_vld  (link_vld[g+1])
    );
  end

  assign head_data = held[0];

`ifndef ASSERT_OFF
  // At most MAX_ENTRIES - 1 intervals are fed, so nothing ever falls off the end.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !link_vld[N])
    else $error("sorting chain overflowed");
`endif

endmodule
`default_nettype wire

@@ sv/pulse_capture_median_interval_unit.sv @@
// Top level: pulse edge capture, width and interval stores, and median of intervals.
// Start, edge and unused commands, and a median of fewer than two pulses, go from idle
// straight to the emit state; reads pass through a read state for the RAM data first.
// Median of n intervals, k = n/2: n feeds from the interval RAM, a drain of the chain,
// k shifts and a load; one item at a time, and output stalls hold the result in emit.
// Reset is synchronous and active low; counts, times and thresholds reset, RAMs are kept.
`default_nettype none
module pulse_capture_median_interval_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pcmi_in_if.sink     in_chan,
  pcmi_out_if.source  out_chan,
  pcmi_cfg_if.sink    cfg_chan
);

  localparam int AW = pcmi_pkg::ENTRY_AW;
  localparam int CW = pcmi_pkg::CNT_W;
  localparam int TW = pcmi_pkg::TS_W;

  pcmi_pkg::state_t st_r, st_nxt;

  logic [TW-1:0] min_width_r, min_gap_r;
  logic [TW-1:0] start_r, start_nxt;
  logic [TW-1:0] last_r, last_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [pcmi_pkg::REJ_W-1:0] rej_r, rej_nxt;

  logic [CW-1:0] seq_r, seq_nxt;
  logic [AW-1:0] n_r, n_nxt;
  logic          feed_vld_r;
  logic          oor_r, oor_nxt;
  logic          sel_width_r, sel_width_nxt;
  logic [TW-1:0] res_value_r, res_value_nxt;
  logic [pcmi_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;

  logic          out_valid_r;
  logic [TW-1:0] out_value_r;
  logic [pcmi_pkg::STATUS_W-1:0] out_status_r;
  logic [CW-1:0] out_total_r;
  logic [pcmi_pkg::REJ_W-1:0] out_rej_r;

  logic          in_acc, out_free;
  logic [TW-1:0] pw, gap;
  logic          w_we, i_we;
  logic [AW-1:0] i_raddr;
  logic [TW-1:0] w_rdata, i_rdata, head_data;
  pcmi_pkg::chain_ctl_t ctl;

  assign in_chan.ready  = (st_r == pcmi_pkg::ST_IDLE);
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign out_free       = !out_valid_r || out_chan.ready;

  assign pw  = in_chan.timestamp - start_r;
  assign gap = start_r - last_r;

  always_comb begin
    st_nxt         = st_r;
    start_nxt      = start_r;
    last_nxt       = last_r;
    cnt_nxt        = cnt_r;
    rej_nxt        = rej_r;
    seq_nxt        = seq_r;
    n_nxt          = n_r;
    oor_nxt        = oor_r;
    sel_width_nxt  = sel_width_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    w_we           = 1'b0;
    i_we           = 1'b0;
    i_raddr        = in_chan.index;
    ctl            = '0;
    case (st_r)
      pcmi_pkg::ST_IDLE: begin
        if (in_acc) begin
          res_value_nxt  = '0;
          res_status_nxt = pcmi_pkg::EDGE_NONE;
          st_nxt         = pcmi_pkg::ST_EMIT;
          case (in_chan.cmd)
            pcmi_pkg::CMD_START: begin
              cnt_nxt   = '0;
              rej_nxt   = '0;
              start_nxt = '0;
              last_nxt  = '0;
            end
            pcmi_pkg::CMD_FALL: begin
              start_nxt = in_chan.timestamp;
            end
            pcmi_pkg::CMD_RISE: begin
              if (pw <= min_width_r) begin
                res_status_nxt = pcmi_pkg::EDGE_NARROW;
                if (rej_r != pcmi_pkg::REJECT_MAX) rej_nxt = rej_r + 1'b1;
              end else if (cnt_r != '0 && gap <= min_gap_r) begin
                res_status_nxt = pcmi_pkg::EDGE_TOO_CLOSE;
                if (rej_r != pcmi_pkg::REJECT_MAX) rej_nxt = rej_r + 1'b1;
              end else begin
                res_status_nxt = pcmi_pkg::EDGE_ACCEPTED;
                last_nxt       = start_r;
                if (cnt_r < CW'(pcmi_pkg::MAX_ENTRIES)) begin
                  w_we    = 1'b1;
                  i_we    = (cnt_r != '0);
                  cnt_nxt = cnt_r + 1'b1;
                end
              end
            end
            pcmi_pkg::CMD_MEDIAN: begin
              if (cnt_r >= CW'(2)) begin
                n_nxt   = AW'(cnt_r - 1'b1);
                seq_nxt = '0;
                ctl.clear = 1'b1;
                st_nxt  = pcmi_pkg::ST_FEED;
              end
            end
            pcmi_pkg::CMD_READ_WIDTH: begin
              oor_nxt       = ({1'b0, in_chan.index} >= cnt_r);
              sel_width_nxt = 1'b1;
              st_nxt        = pcmi_pkg::ST_READ;
            end
            pcmi_pkg::CMD_READ_INTERVAL: begin
              oor_nxt       = ({1'b0, in_chan.index} + 1'b1 >= cnt_r);
              sel_width_nxt = 1'b0;
              st_nxt        = pcmi_pkg::ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      pcmi_pkg::ST_READ: begin
        if (oor_r) res_value_nxt = pcmi_pkg::VALUE_OOR;
        else       res_value_nxt = sel_width_r ? w_rdata : i_rdata;
        st_nxt = pcmi_pkg::ST_EMIT;
      end
      pcmi_pkg::ST_FEED: begin
        i_raddr = seq_r[AW-1:0];
        if (seq_r[AW-1:0] == n_r - 1'b1) begin
          seq_nxt = '0;
          st_nxt  = pcmi_pkg::ST_DRAIN;
        end else begin
          seq_nxt = seq_r + 1'b1;
        end
      end
      pcmi_pkg::ST_DRAIN: begin
        // Long enough for a value handed on at the last feed to settle at the tail.
        if (seq_r == CW'(pcmi_pkg::MAX_ENTRIES)) begin
          seq_nxt = '0;
          st_nxt  = pcmi_pkg::ST_SHIFT;
        end else begin
          seq_nxt = seq_r + 1'b1;
        end
      end
      pcmi_pkg::ST_SHIFT: begin
        if (seq_r == CW'(n_r >> 1)) begin
          res_value_nxt = head_data;
          st_nxt        = pcmi_pkg::ST_EMIT;
        end else begin
          ctl.shift = 1'b1;
          seq_nxt   = seq_r + 1'b1;
        end
      end
      pcmi_pkg::ST_EMIT: begin
        if (out_free) st_nxt = pcmi_pkg::ST_IDLE;
      end
      default: begin
        st_nxt = pcmi_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= pcmi_pkg::ST_IDLE;
      min_width_r <= pcmi_pkg::MIN_WIDTH_RESET;
      min_gap_r   <= pcmi_pkg::MIN_GAP_RESET;
      start_r     <= '0;
      last_r      <= '0;
      cnt_r       <= '0;
      rej_r       <= '0;
      seq_r       <= '0;
      feed_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      start_r    <= start_nxt;
      last_r     <= last_nxt;
      cnt_r      <= cnt_nxt;
      rej_r      <= rej_nxt;
      seq_r      <= seq_nxt;
      feed_vld_r <= (st_r == pcmi_pkg::ST_FEED);
      if (cfg_chan.valid && cfg_chan.ready) begin
        if (cfg_chan.index == pcmi_pkg::REG_MIN_WIDTH) min_width_r <= cfg_chan.data;
        if (cfg_chan.index == pcmi_pkg::REG_MIN_GAP)   min_gap_r   <= cfg_chan.data;
      end
      if (st_r == pcmi_pkg::ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    n_r          <= n_nxt;
    oor_r        <= oor_nxt;
    sel_width_r  <= sel_width_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    if (st_r == pcmi_pkg::ST_EMIT && out_free) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
      out_total_r  <= cnt_r;
      out_rej_r    <= rej_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.value        = out_value_r;
  assign out_chan.edge_status  = out_status_r;
  assign out_chan.pulse_total  = out_total_r;
  assign out_chan.reject_total = out_rej_r;

  pcmi_ram #(.WIDTH(TW), .DEPTH(pcmi_pkg::MAX_ENTRIES)) u_width_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (pw),
    .raddr (in_chan.index),
    .rdata (w_rdata)
  );

  pcmi_ram #(.WIDTH(TW), .DEPTH(pcmi_pkg::MAX_ENTRIES)) u_interval_ram (
    .clk   (clk),
    .we    (i_we),
    .waddr (AW'(cnt_r - 1'b1)),
    .wdata (gap),
    .raddr (i_raddr),
    .rdata (i_rdata)
  );

  pcmi_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .feed_data (i_rdata),
    .feed_vld  (feed_vld_r),
    .head_data (head_data)
  );

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(pcmi_pkg::MAX_ENTRIES))
    else $error("pulse count beyond capacity");

  a_feed_origin: assert property (@(posedge clk) disable iff (!rst_n)
    feed_vld_r |-> $past(st_r == pcmi_pkg::ST_FEED))
    else $error("chain fed outside the feed phase");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == pcmi_pkg::ST_EMIT && out_free) |=> (out_valid_r && st_r == pcmi_pkg::ST_IDLE))
    else $error("result not loaded into the output register");

  a_store_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (w_we || i_we) |-> (in_acc && in_chan.cmd == pcmi_pkg::CMD_RISE))
    else $error("store written without an accepted rising edge");
`endif

endmodule
`default_nettype wire

@@ sim/pulse_capture_median_interval_unit_test.sv @@
// Testbench for the pulse capture unit: directed and random edge traffic against a predictor.
module pulse_capture_median_interval_unit_test;

  localparam logic [pcmi_pkg::CMD_W-1:0] CMD_RESERVED_LO = 3'd6;
  localparam logic [pcmi_pkg::CMD_W-1:0] CMD_RESERVED_HI = 3'd7;

  typedef struct packed {
    logic [pcmi_pkg::TS_W-1:0]     value;
    logic [pcmi_pkg::STATUS_W-1:0] edge_status;
    logic [pcmi_pkg::CNT_W-1:0]    pulse_total;
    logic [pcmi_pkg::REJ_W-1:0]    reject_total;
  } capture_result_t;

  logic clk = 1'b0;
  logic rst_n;

  pcmi_in_if  in_chan ();
  pcmi_out_if out_chan ();
  pcmi_cfg_if cfg_chan ();

  pulse_capture_median_interval_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state and thresholds.
  logic [pcmi_pkg::TS_W-1:0] cfg_min_width;
  logic [pcmi_pkg::TS_W-1:0] cfg_min_gap;
  logic [pcmi_pkg::TS_W-1:0] fall_time;
  logic [pcmi_pkg::TS_W-1:0] last_valid_fall;
  int                        stored_pulses;
  int                        reject_count;
  logic [pcmi_pkg::TS_W-1:0] width_log [pcmi_pkg::MAX_ENTRIES];
  logic [pcmi_pkg::TS_W-1:0] gap_log [pcmi_pkg::MAX_ENTRIES];

  capture_result_t awaited_results [$];

  int in_idle_pct;
  int out_idle_pct;
  int items_sent;
  int results_checked;
  int error_count;
  int accepted_edges;
  int narrow_edges;
  int close_edges;
  int saturated_results;
  logic [pcmi_pkg::TS_W-1:0] last_fall_stamp;

  function automatic capture_result_t next_capture_result(logic [pcmi_pkg::CMD_W-1:0] cmd,
                                                          logic [pcmi_pkg::TS_W-1:0] ts,
                                                          logic [pcmi_pkg::IDX_W-1:0] idx);
    capture_result_t res;
    logic [pcmi_pkg::TS_W-1:0] width;
    logic [pcmi_pkg::TS_W-1:0] gap;
    logic [pcmi_pkg::TS_W-1:0] v;
    logic [pcmi_pkg::TS_W-1:0] sorted [pcmi_pkg::MAX_ENTRIES];
    int n, i, j;
    res = '0;
    case (cmd)
      pcmi_pkg::CMD_START: begin
        stored_pulses = 0;
        reject_count = 0;
        fall_time = '0;
        last_valid_fall = '0;
      end
      pcmi_pkg::CMD_FALL: fall_time = ts;
      pcmi_pkg::CMD_RISE: begin
        width = ts - fall_time;
        gap = fall_time - last_valid_fall;
        if (width <= cfg_min_width) begin
          res.edge_status = pcmi_pkg::EDGE_NARROW;
          if (reject_count < 255) reject_count++;
        end else if (stored_pulses > 0 && gap <= cfg_min_gap) begin
          res.edge_status = pcmi_pkg::EDGE_TOO_CLOSE;
          if (reject_count < 255) reject_count++;
        end else begin
          res.edge_status = pcmi_pkg::EDGE_ACCEPTED;
          // A full store still moves the last valid start forward.
          if (stored_pulses < pcmi_pkg::MAX_ENTRIES) begin
            width_log[stored_pulses] = width;
            if (stored_pulses > 0) gap_log[stored_pulses - 1] = gap;
            stored_pulses++;
          end
          last_valid_fall = fall_time;
        end
      end
      pcmi_pkg::CMD_MEDIAN: begin
        if (stored_pulses >= 2) begin
          n = stored_pulses - 1;
          for (i = 0; i < n; i++) sorted[i] = gap_log[i];
          for (i = 1; i < n; i++) begin
            v = sorted[i];
            j = i;
            while (j > 0 && sorted[j - 1] > v) begin
              sorted[j] = sorted[j - 1];
              j--;
            end
            sorted[j] = v;
          end
          res.value = sorted[n >> 1];
        end
      end
      pcmi_pkg::CMD_READ_WIDTH:
        res.value = (int'(idx) >= stored_pulses) ? pcmi_pkg::VALUE_OOR : width_log[idx];
      pcmi_pkg::CMD_READ_INTERVAL:
        res.value = (int'(idx) + 1 >= stored_pulses) ? pcmi_pkg::VALUE_OOR : gap_log[idx];
      default: ;
    endcase
    res.pulse_total = pcmi_pkg::CNT_W'(stored_pulses);
    res.reject_total = pcmi_pkg::REJ_W'(reject_count);
    return res;
  endfunction

  task automatic send_item(logic [pcmi_pkg::CMD_W-1:0] cmd, logic [pcmi_pkg::TS_W-1:0] ts,
                           logic [pcmi_pkg::IDX_W-1:0] idx);
    if ($urandom_range(99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_chan.valid <= 1'b1;
    in_chan.cmd <= cmd;
    in_chan.timestamp <= ts;
    in_chan.index <= idx;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    awaited_results.push_back(next_capture_result(cmd, ts, idx));
    items_sent++;
  endtask

  task automatic write_reg(logic [pcmi_pkg::CFG_IDX_W-1:0] idx,
                           logic [pcmi_pkg::TS_W-1:0] data);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= data;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    if (idx == pcmi_pkg::REG_MIN_WIDTH) cfg_min_width = data;
    else cfg_min_gap = data;
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  // Span near a threshold: on it, just above it, anywhere, or comfortably above it.
  function automatic logic [pcmi_pkg::TS_W-1:0] pick_span(logic [pcmi_pkg::TS_W-1:0] floor_ticks);
    int r;
    r = $urandom_range(99);
    if (r < 10) return floor_ticks;
    if (r < 20) return floor_ticks + 16'd1;
    if (r < 30) return pcmi_pkg::TS_W'($urandom_range(65535));
    return floor_ticks + 16'd1 + pcmi_pkg::TS_W'($urandom_range(3000));
  endfunction

  task automatic run_random_traffic(int n_items, bit allow_start, int lone_pct);
    int first, pick;
    logic [pcmi_pkg::TS_W-1:0] ts;
    logic [pcmi_pkg::IDX_W-1:0] idx;
    first = items_sent;
    while (items_sent - first < n_items) begin
      pick = $urandom_range(99);
      if (pick < lone_pct) begin
        // Broken sequences: a rise without a new fall, or a fall at a random time.
        if ($urandom_range(1)) begin
          send_item(pcmi_pkg::CMD_RISE, last_fall_stamp + pick_span(cfg_min_width), '0);
        end else begin
          last_fall_stamp = pcmi_pkg::TS_W'($urandom_range(65535));
          send_item(pcmi_pkg::CMD_FALL, last_fall_stamp,
                    pcmi_pkg::IDX_W'($urandom_range(31)));
        end
      end else if (pick < lone_pct + 15) begin
        if ($urandom_range(1)) idx = pcmi_pkg::IDX_W'($urandom_range(31));
        else idx = pcmi_pkg::IDX_W'((stored_pulses > 31) ? 31 : $urandom_range(stored_pulses));
        case ($urandom_range(2))
          0: send_item(pcmi_pkg::CMD_MEDIAN, pcmi_pkg::TS_W'($urandom_range(65535)), idx);
          1: send_item(pcmi_pkg::CMD_READ_WIDTH, pcmi_pkg::TS_W'($urandom_range(65535)), idx);
          default: send_item(pcmi_pkg::CMD_READ_INTERVAL,
                             pcmi_pkg::TS_W'($urandom_range(65535)), idx);
        endcase
      end else if (pick < lone_pct + 17) begin
        send_item($urandom_range(1) ? CMD_RESERVED_HI : CMD_RESERVED_LO,
                  pcmi_pkg::TS_W'($urandom_range(65535)),
                  pcmi_pkg::IDX_W'($urandom_range(31)));
      end else if (allow_start && pick < lone_pct + 18) begin
        send_item(pcmi_pkg::CMD_START, pcmi_pkg::TS_W'($urandom_range(65535)),
                  pcmi_pkg::IDX_W'($urandom_range(31)));
      end else begin
        last_fall_stamp = last_fall_stamp + pick_span(cfg_min_gap);
        send_item(pcmi_pkg::CMD_FALL, last_fall_stamp, '0);
        ts = last_fall_stamp + pick_span(cfg_min_width);
        send_item(pcmi_pkg::CMD_RISE, ts, '0);
      end
    end
  endtask

  task automatic check_field(string name, int expected, int actual);
    if (expected != actual) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expected, actual);
      error_count++;
    end
  endtask

  // Receiver: random back-pressure and a field-by-field check of each result.
  initial begin
    capture_result_t exp_res;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with nothing expected: value %0d status %0d", $time,
                   out_chan.value, out_chan.edge_status);
          error_count++;
        end else begin
          exp_res = awaited_results.pop_front();
          check_field("value", exp_res.value, out_chan.value);
          check_field("edge_status", exp_res.edge_status, out_chan.edge_status);
          check_field("pulse_total", exp_res.pulse_total, out_chan.pulse_total);
          check_field("reject_total", exp_res.reject_total, out_chan.reject_total);
          results_checked++;
          case (exp_res.edge_status)
            pcmi_pkg::EDGE_ACCEPTED: accepted_edges++;
            pcmi_pkg::EDGE_NARROW: narrow_edges++;
            pcmi_pkg::EDGE_TOO_CLOSE: close_edges++;
            default: ;
          endcase
          if (exp_res.reject_total == pcmi_pkg::REJECT_MAX) saturated_results++;
        end
      end
      out_chan.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic test_reset_defaults();
    send_item(pcmi_pkg::CMD_MEDIAN, 16'd0, 5'd0);
    send_item(pcmi_pkg::CMD_READ_WIDTH, 16'd0, 5'd0);
    send_item(pcmi_pkg::CMD_READ_INTERVAL, 16'hFFFF, 5'd31);
    send_item(pcmi_pkg::CMD_START, 16'd0, 5'd0);
  endtask

  // Boundary widths and gaps, plus a width that wraps past the top of the timer.
  task automatic test_edge_rules();
    send_item(pcmi_pkg::CMD_FALL, 16'd1000, 5'd0);
    send_item(pcmi_pkg::CMD_RISE, 16'd1625, 5'd0);
    send_item(pcmi_pkg::CMD_FALL, 16'd2000, 5'd0);
    send_item(pcmi_pkg::CMD_RISE, 16'd2626, 5'd0);
    send_item(pcmi_pkg::CMD_FALL, 16'd5125, 5'd0);
    send_item(pcmi_pkg::CMD_RISE, 16'd6125, 5'd0);
    send_item(pcmi_pkg::CMD_FALL, 16'd5126, 5'd0);
    send_item(pcmi_pkg::CMD_RISE, 16'd6500, 5'd0);
    send_item(pcmi_pkg::CMD_MEDIAN, 16'd0, 5'd0);
    send_item(pcmi_pkg::CMD_FALL, 16'd65000, 5'd0);
    send_item(pcmi_pkg::CMD_RISE, 16'd1000, 5'd0);
    send_item(pcmi_pkg::CMD_MEDIAN, 16'd0, 5'd0);
  endtask

  task automatic test_index_reads();
    send_item(pcmi_pkg::CMD_READ_WIDTH, 16'd0, 5'd2);
    send_item(pcmi_pkg::CMD_READ_WIDTH, 16'd0, 5'd3);
    send_item(pcmi_pkg::CMD_READ_INTERVAL, 16'd0, 5'd1);
    send_item(pcmi_pkg::CMD_READ_INTERVAL, 16'd0, 5'd2);
  endtask

  task automatic test_reserved_commands();
    send_item(CMD_RESERVED_LO, 16'hFFFF, 5'd31);
    send_item(CMD_RESERVED_HI, 16'd0, 5'd0);
  endtask

  task automatic test_start_clears();
    send_item(pcmi_pkg::CMD_START, 16'hFFFF, 5'd31);
    send_item(pcmi_pkg::CMD_READ_WIDTH, 16'd0, 5'd0);
    send_item(pcmi_pkg::CMD_MEDIAN, 16'd0, 5'd0);
  endtask

  task automatic test_random_default_thresholds();
    drain_results();
    write_reg(pcmi_pkg::REG_MIN_WIDTH, pcmi_pkg::MIN_WIDTH_RESET);
    write_reg(pcmi_pkg::REG_MIN_GAP, pcmi_pkg::MIN_GAP_RESET);
    run_random_traffic(220, 1'b1, 8);
  endtask

  task automatic test_random_open_thresholds();
    drain_results();
    in_idle_pct = 71;
    out_idle_pct = 17;
    write_reg(pcmi_pkg::REG_MIN_WIDTH, 16'd0);
    write_reg(pcmi_pkg::REG_MIN_GAP, 16'd0);
    run_random_traffic(130, 1'b1, 8);
  endtask

  // Every width is too narrow here, so the reject count runs into its ceiling.
  task automatic test_reject_saturation();
    drain_results();
    in_idle_pct = 0;
    out_idle_pct = 0;
    write_reg(pcmi_pkg::REG_MIN_WIDTH, 16'hFFFF);
    write_reg(pcmi_pkg::REG_MIN_GAP, pcmi_pkg::TS_W'($urandom_range(65535)));
    repeat (260) send_item(pcmi_pkg::CMD_RISE, pcmi_pkg::TS_W'($urandom_range(65535)), '0);
    run_random_traffic(190, 1'b0, 60);
  endtask

  task automatic test_random_tight_gap();
    drain_results();
    write_reg(pcmi_pkg::REG_MIN_WIDTH, pcmi_pkg::TS_W'($urandom_range(1000)));
    write_reg(pcmi_pkg::REG_MIN_GAP, 16'hFFFF);
    send_item(pcmi_pkg::CMD_START, 16'd0, 5'd0);
    run_random_traffic(100, 1'b1, 8);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.cmd <= pcmi_pkg::CMD_START;
    in_chan.timestamp <= '0;
    in_chan.index <= '0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.index <= pcmi_pkg::REG_MIN_WIDTH;
    cfg_chan.data <= '0;
    cfg_min_width = pcmi_pkg::MIN_WIDTH_RESET;
    cfg_min_gap = pcmi_pkg::MIN_GAP_RESET;
    fall_time = '0;
    last_valid_fall = '0;
    stored_pulses = 0;
    reject_count = 0;
    in_idle_pct = 17;
    out_idle_pct = 71;
    items_sent = 0;
    results_checked = 0;
    error_count = 0;
    accepted_edges = 0;
    narrow_edges = 0;
    close_edges = 0;
    saturated_results = 0;
    last_fall_stamp = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_edge_rules();
    test_index_reads();
    test_reserved_commands();
    test_start_clears();
    test_random_default_thresholds();
    test_random_open_thresholds();
    test_reject_saturation();
    test_random_tight_gap();

    drain_results();
    repeat (100) @(posedge clk);
    $display("Sent %0d items and checked %0d results across four threshold settings.",
             items_sent, results_checked);
    $display("Rising edges: %0d accepted, %0d too narrow, %0d too close; %0d at reject cap.",
             accepted_edges, narrow_edges, close_edges, saturated_results);
    if (error_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #5000000;
    $display("%0t: timeout with %0d results outstanding", $time, awaited_results.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
